/* sv/mbe_pkg.sv */
// Shared types and constants for the Mandelbrot escape-time unit.
// Used by the controller, the datapath and the top level. No dependencies.
package mbe_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned CntW   = 16;
  localparam int unsigned ProdW  = 2 * CoordW;
  // Width for the exact update sums before saturation.
  localparam int unsigned SumW   = ProdW + 2;

  localparam logic [CntW-1:0] MaxIterReset = 16'd1000;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_UPD  = 4'b0100,
    ST_HOLD = 4'b1000
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;  // load c, clear z and the count
    logic mul;    // register the three products of the current z
    logic upd;    // write the next z and bump the count
    logic emit;   // load the result register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic escape;    // |z|^2 has reached 4
    logic at_limit;  // count has reached the iteration limit
  } sts_t;

endpackage

/* sv/mandelbrot_escape_time_top.sv */
// Top level of the Mandelbrot escape-time unit.
// Instantiates mbe_ctrl and mbe_dpath; uses mbe_pkg for widths.
//
//   Channel  Direction  Handshake           Payload
//   in_      slave      in_tvalid/tready    tdata = c_real, c_imag
//   out_     master     out_tvalid/tready   tdata = escape_count, tuser = in_set
//   cfg_     write      cfg_wr_en           cfg_wr_data = max_iterations
//
// Each iteration of z = z*z + c runs ST_MUL, which registers the three 32x32
// products, then ST_UPD, which runs the escape test and the saturating update.
// When the escape test or the iteration limit ends a point, its result goes to
// the output register and the controller returns to ST_IDLE for the next one.
// The result sits in an output register, so a new point is accepted while
// the previous result waits; the core only stalls when a second result is
// ready and the output register is still full.
// Reset is synchronous and active low; it sets max_iterations to 1000.
module mandelbrot_escape_time_top #(
  parameter int unsigned FRAC_BITS = 28
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input points.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] c_real, [63:32] c_imag
  // Results.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] escape_count
  output logic        out_tuser,  // [0] in_set
  // Iteration limit register.
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);
  import mbe_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // The controller sequences the multiply and update cycles and owns the
  // output valid flag.
  mbe_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // The datapath holds z, c, the count, the limit and the result payload.
  mbe_dpath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .c_real       (in_tdata[CoordW-1:0]),
    .c_imag       (in_tdata[2*CoordW-1:CoordW]),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .cmd          (cmd),
    .sts          (sts),
    .escape_count (out_tdata),
    .in_set       (out_tuser)
  );

endmodule

/* sv/mbe_ctrl.sv */
// Controller state machine of the Mandelbrot escape-time unit.
// Depends on mbe_pkg for the state, command and status types.
module mbe_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  input  mbe_pkg::sts_t sts,
  output mbe_pkg::cmd_t cmd
);
  import mbe_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;
  logic   finish;

  assign slot_free  = !out_valid_r || out_tready;
  assign finish     = sts.escape || sts.at_limit;
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.start = 1'b1;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        if (finish) begin
          if (slot_free) begin
            cmd.emit  = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_HOLD;
          end
        end else begin
          cmd.upd   = 1'b1;
          state_nxt = ST_MUL;
        end
      end
      ST_HOLD: begin
        if (slot_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* sv/mbe_dpath.sv */
// Datapath of the Mandelbrot escape-time unit: z registers, products,
// escape test, saturating update, count, limit register and result register.
// Depends on mbe_pkg for widths, reset constants and the command/status types.
module mbe_dpath #(
  parameter int unsigned FRAC_BITS = 28
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [mbe_pkg::CoordW-1:0]   c_real,
  input  logic [mbe_pkg::CoordW-1:0]   c_imag,
  input  logic                         cfg_wr_en,
  input  logic [mbe_pkg::CntW-1:0]     cfg_wr_data,
  input  mbe_pkg::cmd_t                cmd,
  output mbe_pkg::sts_t                sts,
  output logic [mbe_pkg::CntW-1:0]     escape_count,
  output logic                         in_set
);
  import mbe_pkg::*;

  localparam logic [ProdW:0] EscLimit = (ProdW + 1)'(4) << FRAC_BITS;

  logic [CoordW-1:0] cr_r, ci_r, x_r, y_r;
  logic [CntW-1:0]   n_r, max_r;
  logic [ProdW-1:0]  pxx_r, pyy_r, pxy_r;
  logic [CntW-1:0]   cnt_out_r;
  logic              in_set_r;

  logic [CoordW-1:0] ax, ay;
  logic [ProdW-1:0]  pxx, pyy, pxy;
  logic [ProdW-1:0]  xx, yy, xy;
  logic [ProdW:0]    mag;
  logic [SumW-1:0]   nx_wide, ny_wide;
  logic [CoordW-1:0] x_nxt, y_nxt;
  logic              hit_limit;

  function automatic logic [CoordW-1:0] sat_coord(input logic [SumW-1:0] v);
    logic [SumW-CoordW:0] top;
    logic [CoordW-1:0]    res;
    top = v[SumW-1:CoordW-1];
    if ((top == '0) || (top == '1)) begin
      res = v[CoordW-1:0];
    end else if (v[SumW-1]) begin
      res = {1'b1, {(CoordW-1){1'b0}}};
    end else begin
      res = {1'b0, {(CoordW-1){1'b1}}};
    end
    return res;
  endfunction

  // Magnitudes of the current z; the most negative value maps to 2^31.
  assign ax  = x_r[CoordW-1] ? (~x_r + 1'b1) : x_r;
  assign ay  = y_r[CoordW-1] ? (~y_r + 1'b1) : y_r;
  assign pxx = {{CoordW{1'b0}}, ax} * {{CoordW{1'b0}}, ax};
  assign pyy = {{CoordW{1'b0}}, ay} * {{CoordW{1'b0}}, ay};
  assign pxy = {{CoordW{x_r[CoordW-1]}}, x_r} * {{CoordW{y_r[CoordW-1]}}, y_r};

  // Fixed-point rescale of the registered products; xy rounds toward minus infinity.
  assign xx  = pxx_r >> FRAC_BITS;
  assign yy  = pyy_r >> FRAC_BITS;
  assign xy  = ProdW'($signed(pxy_r) >>> FRAC_BITS);
  assign mag = {1'b0, xx} + {1'b0, yy};

  assign nx_wide = {2'b00, xx} - {2'b00, yy}
                 + {{(SumW-CoordW){cr_r[CoordW-1]}}, cr_r};
  assign ny_wide = {xy[ProdW-1], xy, 1'b0}
                 + {{(SumW-CoordW){ci_r[CoordW-1]}}, ci_r};
  assign x_nxt   = sat_coord(nx_wide);
  assign y_nxt   = sat_coord(ny_wide);

  assign hit_limit    = (n_r >= max_r);
  assign sts.escape   = (mag >= EscLimit);
  assign sts.at_limit = hit_limit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= MaxIterReset;
    end else if (cfg_wr_en) begin
      max_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      cr_r <= c_real;
      ci_r <= c_imag;
      x_r  <= '0;
      y_r  <= '0;
      n_r  <= '0;
    end else if (cmd.upd) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      n_r <= n_r + 1'b1;
    end
    if (cmd.mul) begin
      pxx_r <= pxx;
      pyy_r <= pyy;
      pxy_r <= pxy;
    end
    if (cmd.emit) begin
      in_set_r  <= hit_limit;
      cnt_out_r <= hit_limit ? '0 : n_r;
    end
  end

  assign escape_count = cnt_out_r;
  assign in_set       = in_set_r;

endmodule
